// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond at an edge implies prop at the same edge
`define NCM_ASSERT_IMPLY(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// cond must never hold
`define NCM_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

// ===== rtl/ncm_pkg.sv =====
// ----------------------------------------------------------------------------
// ncm_pkg
// Types and constants shared by the normalization cube map texel block.
// ----------------------------------------------------------------------------
package ncm_pkg;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  // 255 * 255
  localparam logic [15:0] PACK_SQ = 16'd65025;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic       bad;
    logic [2:0] neg;
    logic [2:0] zero;
  } ctl_t;

endpackage

// ===== rtl/ncm_front.sv =====
// ----------------------------------------------------------------------------
// ncm_front
// Takes requests, forms the direction vector and the squared terms.
// ----------------------------------------------------------------------------
module ncm_front #(
  parameter int FACE_SIZE = 32,
  parameter int MW = 6,
  parameter int QW = 13,
  parameter int RW = 28
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [2:0]           in_face,
  input  logic [4:0]           in_row,
  input  logic [4:0]           in_column,
  output logic [1:0]           inflight,
  output logic                 push,
  output ncm_pkg::ctl_t        push_ctl,
  output logic [QW-1:0]        push_q,
  output logic [2:0][RW-1:0]   push_rhs
);

  localparam int CW = MW + 1;

  logic                 s1_v_r, s2_v_r, s3_v_r;
  logic                 s1_bad_r, s2_bad_r;
  logic signed [CW-1:0] s1_c_r [3];
  logic signed [CW-1:0] c_nxt [3];
  logic                 bad_nxt;
  logic signed [CW-1:0] u, v, s;
  logic [2:0]           s2_neg_r, s2_zero_r;
  logic [2*MW-1:0]      s2_sq_r [3];
  ncm_pkg::ctl_t        s3_ctl_r;
  logic [QW-1:0]        s3_q_r;
  logic [2:0][RW-1:0]   s3_rhs_r;

  assign s = CW'(FACE_SIZE);
  assign u = CW'($signed({1'b0, in_column, 1'b1})) - s;
  assign v = CW'($signed({1'b0, in_row, 1'b1})) - s;

  always_comb begin
    bad_nxt = 1'b0;
    c_nxt[0] = '0;
    c_nxt[1] = '0;
    c_nxt[2] = '0;
    case (in_face)
      ncm_pkg::FACE_PX: begin c_nxt[0] = s;  c_nxt[1] = -v; c_nxt[2] = -u; end
      ncm_pkg::FACE_NX: begin c_nxt[0] = -s; c_nxt[1] = -v; c_nxt[2] = u;  end
      ncm_pkg::FACE_PY: begin c_nxt[0] = u;  c_nxt[1] = s;  c_nxt[2] = v;  end
      ncm_pkg::FACE_NY: begin c_nxt[0] = u;  c_nxt[1] = -s; c_nxt[2] = -v; end
      ncm_pkg::FACE_PZ: begin c_nxt[0] = u;  c_nxt[1] = -v; c_nxt[2] = s;  end
      ncm_pkg::FACE_NZ: begin c_nxt[0] = -u; c_nxt[1] = -v; c_nxt[2] = -s; end
      default: bad_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= take;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [MW-1:0] mag;
    s1_bad_r <= bad_nxt;
    s1_c_r   <= c_nxt;
    s2_bad_r <= s1_bad_r;
    for (int k = 0; k < 3; k++) begin
      mag = s1_c_r[k][CW-1] ? MW'(-s1_c_r[k]) : MW'(s1_c_r[k]);
      s2_neg_r[k]  <= s1_c_r[k][CW-1];
      s2_zero_r[k] <= (s1_c_r[k] == '0);
      s2_sq_r[k]   <= (2*MW)'(mag) * (2*MW)'(mag);
    end
    s3_ctl_r.bad  <= s2_bad_r;
    s3_ctl_r.neg  <= s2_neg_r;
    s3_ctl_r.zero <= s2_zero_r;
    s3_q_r <= QW'(s2_sq_r[0]) + QW'(s2_sq_r[1]) + QW'(s2_sq_r[2]);
    for (int k = 0; k < 3; k++) begin
      s3_rhs_r[k] <= RW'(s2_sq_r[k]) * RW'(ncm_pkg::PACK_SQ);
    end
  end

  assign inflight = 2'(s1_v_r) + 2'(s2_v_r) + 2'(s3_v_r);
  assign push     = s3_v_r;
  assign push_ctl = s3_ctl_r;
  assign push_q   = s3_q_r;
  assign push_rhs = s3_rhs_r;

endmodule

// ===== rtl/ncm_queue.sv =====
// ----------------------------------------------------------------------------
// ncm_queue
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ncm_queue #(
  parameter int W = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [W-1:0]             wdata,
  input  logic                     pop,
  output logic [W-1:0]             rdata,
  output logic [ncm_pkg::QAW:0]    count
);

  localparam int QAW = ncm_pkg::QAW;

  logic [W-1:0]   mem [ncm_pkg::QDEPTH];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QAW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

  assign rdata = mem[rd_r];
  assign count = cnt_r;

  `NCM_ASSERT_NEVER(a_q_overflow, push && !pop && cnt_r == (QAW+1)'(ncm_pkg::QDEPTH))
  `NCM_ASSERT_NEVER(a_q_underflow, pop && cnt_r == '0)

endmodule

// ===== rtl/ncm_step.sv =====
// ----------------------------------------------------------------------------
// ncm_step
// One bit of the packed byte for all three components, three stages deep.
// ----------------------------------------------------------------------------
module ncm_step #(
  parameter int BIT = 7,
  parameter int QW = 13,
  parameter int RW = 28
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                i_v,
  input  ncm_pkg::ctl_t       i_ctl,
  input  logic [QW-1:0]       i_q,
  input  logic [2:0][RW-1:0]  i_rhs,
  input  logic [2:0][7:0]     i_b,
  output logic                o_v,
  output ncm_pkg::ctl_t       o_ctl,
  output logic [QW-1:0]       o_q,
  output logic [2:0][RW-1:0]  o_rhs,
  output logic [2:0][7:0]     o_b
);

  localparam int LW = QW + 16;

  logic               a_v_r, b_v_r, c_v_r;
  ncm_pkg::ctl_t      a_ctl_r, b_ctl_r, c_ctl_r;
  logic [QW-1:0]      a_q_r, b_q_r, c_q_r;
  logic [2:0][RW-1:0] a_rhs_r, b_rhs_r, c_rhs_r;
  logic [2:0][7:0]    a_b_r, a_cand_r, b_b_r, b_cand_r, c_b_r;
  logic [2:0][15:0]   a_ad2_r;
  logic [2:0][LW-1:0] b_lhs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= i_v;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [7:0] cand;
    logic [7:0] ad;
    logic       fits;
    // stage A: candidate and |2b-255|^2
    a_ctl_r <= i_ctl;
    a_q_r   <= i_q;
    a_rhs_r <= i_rhs;
    a_b_r   <= i_b;
    for (int k = 0; k < 3; k++) begin
      cand = i_b[k] | 8'(1 << BIT);
      ad = cand[7] ? 8'({cand[6:0], 1'b1}) : 8'(~{cand[6:0], 1'b0});
      a_cand_r[k] <= cand;
      a_ad2_r[k]  <= 16'(ad) * 16'(ad);
    end
    // stage B: scale by squared length
    b_ctl_r  <= a_ctl_r;
    b_q_r    <= a_q_r;
    b_rhs_r  <= a_rhs_r;
    b_b_r    <= a_b_r;
    b_cand_r <= a_cand_r;
    for (int k = 0; k < 3; k++) begin
      b_lhs_r[k] <= LW'(a_ad2_r[k]) * LW'(a_q_r);
    end
    // stage C: keep the bit when (2b-255)*L <= 255*c
    c_ctl_r <= b_ctl_r;
    c_q_r   <= b_q_r;
    c_rhs_r <= b_rhs_r;
    for (int k = 0; k < 3; k++) begin
      if (!b_cand_r[k][7]) begin
        fits = !b_ctl_r.neg[k] || (b_lhs_r[k] >= LW'(b_rhs_r[k]));
      end else begin
        fits = !b_ctl_r.neg[k] && !b_ctl_r.zero[k] && (b_lhs_r[k] <= LW'(b_rhs_r[k]));
      end
      c_b_r[k] <= fits ? b_cand_r[k] : b_b_r[k];
    end
  end

  assign o_v   = c_v_r;
  assign o_ctl = c_ctl_r;
  assign o_q   = c_q_r;
  assign o_rhs = c_rhs_r;
  assign o_b   = c_b_r;

endmodule

// ===== rtl/ncm_back.sv =====
// ----------------------------------------------------------------------------
// ncm_back
// Eight chained bit steps that build the three packed bytes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ncm_back #(
  parameter int QW = 13,
  parameter int RW = 28
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                i_v,
  input  ncm_pkg::ctl_t       i_ctl,
  input  logic [QW-1:0]       i_q,
  input  logic [2:0][RW-1:0]  i_rhs,
  output logic                out_strobe,
  output logic [7:0]          out_red,
  output logic [7:0]          out_green,
  output logic [7:0]          out_blue
);

  logic                v    [9];
  ncm_pkg::ctl_t       ctl  [9];
  logic [QW-1:0]       q    [9];
  logic [2:0][RW-1:0]  rhs  [9];
  logic [2:0][7:0]     b    [9];

  assign v[0]   = i_v;
  assign ctl[0] = i_ctl;
  assign q[0]   = i_q;
  assign rhs[0] = i_rhs;
  assign b[0]   = '0;

  for (genvar g = 0; g < 8; g++) begin : g_step
    ncm_step #(.BIT(7 - g), .QW(QW), .RW(RW)) u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .i_v   (v[g]),
      .i_ctl (ctl[g]),
      .i_q   (q[g]),
      .i_rhs (rhs[g]),
      .i_b   (b[g]),
      .o_v   (v[g+1]),
      .o_ctl (ctl[g+1]),
      .o_q   (q[g+1]),
      .o_rhs (rhs[g+1]),
      .o_b   (b[g+1])
    );
  end

  assign out_strobe = v[8];
  assign out_red    = ctl[8].bad ? 8'd0 : b[8][0];
  assign out_green  = ctl[8].bad ? 8'd0 : b[8][1];
  assign out_blue   = ctl[8].bad ? 8'd0 : b[8][2];

  // zero component packs to mid scale, negative never above it
  `NCM_ASSERT_IMPLY(a_zero_mid, v[8] && !ctl[8].bad && ctl[8].zero[0], out_red == 8'd127)
  `NCM_ASSERT_IMPLY(a_neg_low, v[8] && !ctl[8].bad && ctl[8].neg[1], out_green <= 8'd127)

endmodule

// ===== rtl/normalization_cube_map_texel.sv =====
// ----------------------------------------------------------------------------
// normalization_cube_map_texel
// Packed unit direction through a cube map texel centre, as RGB bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive in_face, in_row, in_column and raise start; the request
//   is taken at a clock edge where start is high and busy is low.
//   Result: out_red/out_green/out_blue are valid for the single cycle in
//   which out_strobe is high; there is no backpressure on this side.
//   Throughput: one request per cycle. The front (3 stages) forms the
//   vector, its squares and the squared length; a 4-entry queue feeds the
//   back, eight bit steps of three stages each, one per output bit, which
//   resolve the bytes by squared integer compares. busy only rises if the
//   queue plus the front stages would overrun, which steady streaming
//   does not reach.
//   Face codes six and seven return all-zero bytes.
//   Reset: rst_n (synchronous, low) drops every request in flight.
// ----------------------------------------------------------------------------
module normalization_cube_map_texel #(
  parameter int FACE_SIZE = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] in_face,
  input  logic [4:0] in_row,
  input  logic [4:0] in_column,
  output logic       out_strobe,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  localparam int MAG_MAX = (FACE_SIZE > 64 - FACE_SIZE) ? FACE_SIZE : 64 - FACE_SIZE;
  localparam int MW  = $clog2(MAG_MAX + 1);
  localparam int QW  = $clog2(3 * MAG_MAX * MAG_MAX + 1);
  localparam int RW  = 2 * MW + 16;
  localparam int EW  = 7 + QW + 3 * RW;
  localparam int QAW = ncm_pkg::QAW;

  logic               take, push, pop;
  logic [1:0]         inflight;
  ncm_pkg::ctl_t      push_ctl, pop_ctl;
  logic [QW-1:0]      push_q, pop_q;
  logic [2:0][RW-1:0] push_rhs, pop_rhs;
  logic [EW-1:0]      rdata;
  logic [QAW:0]       count;

  assign take = start && !busy;
  assign pop  = (count != '0);
  assign busy = ((QAW+2)'(count) - (QAW+2)'(pop) + (QAW+2)'(inflight))
                >= (QAW+2)'(ncm_pkg::QDEPTH);

  ncm_front #(.FACE_SIZE(FACE_SIZE), .MW(MW), .QW(QW), .RW(RW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_face   (in_face),
    .in_row    (in_row),
    .in_column (in_column),
    .inflight  (inflight),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_q    (push_q),
    .push_rhs  (push_rhs)
  );

  ncm_queue #(.W(EW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata ({push_ctl, push_q, push_rhs}),
    .pop   (pop),
    .rdata (rdata),
    .count (count)
  );

  assign {pop_ctl, pop_q, pop_rhs} = rdata;

  ncm_back #(.QW(QW), .RW(RW)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .i_v        (pop),
    .i_ctl      (pop_ctl),
    .i_q        (pop_q),
    .i_rhs      (pop_rhs),
    .out_strobe (out_strobe),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives face/row/column requests into the cube map texel block and checks
// every returned RGB triple against an exact integer packing predictor.
// ----------------------------------------------------------------------------
module testbench;

  localparam int S = 32;
  localparam int LATENCY = 28;

  typedef struct {
    logic [2:0] face;
    logic [4:0] row;
    logic [4:0] column;
  } texel_req_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [2:0] in_face;
  logic [4:0] in_row;
  logic [4:0] in_column;
  logic       out_strobe;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  texel_req_t pending_reqs[$];
  rgb_t       expected_rgb[$];
  int         mismatches;
  int         gap_left;
  bit         drain_hold;
  bit         no_idle;

  normalization_cube_map_texel u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_face    (in_face),
    .in_row     (in_row),
    .in_column  (in_column),
    .out_strobe (out_strobe),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

  // largest b with (2b-255)*sqrt(q) <= 255*c, settled by squared compares
  function automatic logic [7:0] pack_byte(longint c, longint q);
    logic [7:0] b;
    logic [7:0] cand;
    longint d;
    longint lhs;
    longint rhs;
    bit ok;
    b = '0;
    for (int k = 7; k >= 0; k--) begin
      cand = b | (8'd1 << k);
      d = 2 * longint'(cand) - 255;
      lhs = d * d * q;
      rhs = 65025 * c * c;
      if (d < 0) ok = (c >= 0) ? 1'b1 : (lhs >= rhs);
      else ok = (c <= 0) ? 1'b0 : (lhs <= rhs);
      if (ok) b = cand;
    end
    return b;
  endfunction

  function automatic rgb_t texel_rgb(texel_req_t r);
    rgb_t o;
    longint u;
    longint v;
    longint x;
    longint y;
    longint z;
    longint q;
    u = 2 * longint'(r.column) + 1 - S;
    v = 2 * longint'(r.row) + 1 - S;
    case (r.face)
      ncm_pkg::FACE_PX: begin x = S;  y = -v; z = -u; end
      ncm_pkg::FACE_NX: begin x = -S; y = -v; z = u;  end
      ncm_pkg::FACE_PY: begin x = u;  y = S;  z = v;  end
      ncm_pkg::FACE_NY: begin x = u;  y = -S; z = -v; end
      ncm_pkg::FACE_PZ: begin x = u;  y = -v; z = S;  end
      ncm_pkg::FACE_NZ: begin x = -u; y = -v; z = -S; end
      default: begin
        o.red = '0; o.green = '0; o.blue = '0;
        return o;
      end
    endcase
    q = x * x + y * y + z * z;
    o.red = pack_byte(x, q);
    o.green = pack_byte(y, q);
    o.blue = pack_byte(z, q);
    return o;
  endfunction

  function automatic texel_req_t mk_req(int f, int r, int c);
    texel_req_t t;
    t.face = f[2:0];
    t.row = r[4:0];
    t.column = c[4:0];
    return t;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else if (start && busy) begin
      // hold current request
    end else begin
      if (start) expected_rgb.push_back(texel_rgb(mk_req(in_face, in_row, in_column)));
      if (drain_hold || pending_reqs.size() == 0) begin
        start <= 1'b0;
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 2);
      end else begin
        texel_req_t t;
        t = pending_reqs.pop_front();
        start <= 1'b1;
        in_face <= t.face;
        in_row <= t.row;
        in_column <= t.column;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
                                       out_red, out_green, out_blue);
      end else begin
        rgb_t e;
        e = expected_rgb.pop_front();
        if (e.red !== out_red || e.green !== out_green || e.blue !== out_blue) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                     e.red, e.green, e.blue, out_red, out_green, out_blue);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_face = '0;
    in_row = '0;
    in_column = '0;
    mismatches = 0;
    drain_hold = 1'b0;
    no_idle = 1'b0;
    // directed: all faces at corners, bad face codes
    for (int f = 0; f < 8; f++) begin
      pending_reqs.push_back(mk_req(f, 0, 0));
      pending_reqs.push_back(mk_req(f, 31, 31));
    end
    pending_reqs.push_back(mk_req(ncm_pkg::FACE_PX, 0, 31));
    pending_reqs.push_back(mk_req(ncm_pkg::FACE_NY, 31, 0));
    pending_reqs.push_back(mk_req(ncm_pkg::FACE_PZ, 15, 16));
    pending_reqs.push_back(mk_req(ncm_pkg::FACE_NZ, 16, 15));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_reqs.size() == 0);
    // let everything drain before continuing
    drain_hold = 1'b1;
    @(posedge clk);
    wait (expected_rgb.size() == 0 && !start);
    drain_hold = 1'b0;
    for (int n = 0; n < 1000; n++) begin
      int f;
      f = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
      pending_reqs.push_back(mk_req(f, $urandom_range(0, 31), $urandom_range(0, 31)));
    end
    wait (pending_reqs.size() < 150);
    no_idle = 1'b1;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    @(posedge clk);
    wait (expected_rgb.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    if (mismatches == 0 && expected_rgb.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
